// ===== design/dcc_pkg.sv =====
package dcc_pkg;

   // controller sequence
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // value kinds
   localparam logic [1:0] KIND_VOLT       = 2'd0;
   localparam logic [1:0] KIND_RAW        = 2'd1;
   localparam logic [1:0] KIND_PRESS_VOLT = 2'd2;
   localparam logic [1:0] KIND_PRESS_RAW  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_PRESS_RANGE = 3'd0;
   localparam logic [2:0] REG_KEEP_POS    = 3'd1;
   localparam logic [2:0] REG_NULL_OFFSET = 3'd2;
   localparam logic [2:0] REG_LVDT_OFFSET = 3'd3;
   localparam logic [2:0] REG_AXIS_ONE    = 3'd4;
   localparam logic [2:0] REG_AXIS_TWO    = 3'd5;

   // pressure window modes
   localparam logic [2:0] RANGE_2V5 = 3'd0;
   localparam logic [2:0] RANGE_5V  = 3'd1;

   localparam logic [13:0] FULL_SCALE   = 14'h3fff;
   localparam logic [13:0] MID_SCALE    = 14'd8192;
   localparam logic [13:0] PRESS_HIGH   = 14'd12287;
   localparam logic [13:0] PRESS_LOW    = 14'd4096;
   localparam logic [13:0] PRESS_HIGH_2 = 14'd10239;
   localparam logic [13:0] PRESS_LOW_2  = 14'd6145;
   localparam logic [9:0]  COUNTS_PER_V = 10'd819;
   localparam logic [13:0] MV_SPAN      = 14'd10000;

   // ceil(2^36 / 1000), exact for dividends below 2^26
   localparam logic [26:0] RECIP_1000 = 27'd68719477;
   localparam int          RECIP_SHIFT = 36;

   typedef struct packed {
      logic [2:0]         press_range_mode;
      logic               keep_positive;
      logic signed [14:0] null_offset_mv;
      logic signed [14:0] lvdt_offset_mv;
      logic [2:0]         axis_one_channel;
      logic [2:0]         axis_two_channel;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // unsigned magnitude / 1000, truncating
   function automatic logic [16:0] div1000(input logic [25:0] mag);
      logic [52:0] prod;
      prod = {27'd0, mag} * {26'd0, RECIP_1000};
      return prod[52:RECIP_SHIFT];
   endfunction

endpackage

// ===== design/dcc_csr.sv =====
module dcc_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready,
   output dcc_pkg::cfg_type cfg
);
   import dcc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PRESS_RANGE: cfg_in.press_range_mode = csr_pwdata[2:0];
            REG_KEEP_POS:    cfg_in.keep_positive    = csr_pwdata[0];
            REG_NULL_OFFSET: cfg_in.null_offset_mv   = csr_pwdata[14:0];
            REG_LVDT_OFFSET: cfg_in.lvdt_offset_mv   = csr_pwdata[14:0];
            REG_AXIS_ONE:    cfg_in.axis_one_channel = csr_pwdata[2:0];
            REG_AXIS_TWO:    cfg_in.axis_two_channel = csr_pwdata[2:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_range_mode <= RANGE_2V5;
         cfg_ff.keep_positive    <= 1'b0;
         cfg_ff.null_offset_mv   <= '0;
         cfg_ff.lvdt_offset_mv   <= '0;
         cfg_ff.axis_one_channel <= 3'd1;
         cfg_ff.axis_two_channel <= 3'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PRESS_RANGE: csr_prdata = {29'd0, cfg_ff.press_range_mode};
         REG_KEEP_POS:    csr_prdata = {31'd0, cfg_ff.keep_positive};
         REG_NULL_OFFSET: csr_prdata = {17'd0, cfg_ff.null_offset_mv};
         REG_LVDT_OFFSET: csr_prdata = {17'd0, cfg_ff.lvdt_offset_mv};
         REG_AXIS_ONE:    csr_prdata = {29'd0, cfg_ff.axis_one_channel};
         REG_AXIS_TWO:    csr_prdata = {29'd0, cfg_ff.axis_two_channel};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/dcc_ctrl.sv =====
module dcc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dcc_pkg::dp_status_type status,
   output dcc_pkg::ctrl_cmd_type  cmd
);
   import dcc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the response
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/dcc_datapath.sv =====
module dcc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dcc_pkg::ctrl_cmd_type  cmd,
   output dcc_pkg::dp_status_type status,
   input  dcc_pkg::cfg_type       cfg,
   input  logic [2:0]             channel,
   input  logic signed [16:0]     value,
   input  logic [1:0]             value_kind,
   input  logic                   incremental,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [14:0]            dac_frame,
   output logic                   status_bad
);
   import dcc_pkg::*;

   // channel word store
   logic [13:0] store_ff [4];
   logic [13:0] store_wr_in;

   // capture stage
   logic [1:0]         idx;
   logic [13:0]        word;
   logic signed [14:0] word_dev;
   logic signed [28:0] dev_prod;
   logic signed [28:0] dev_biased;
   logic signed [14:0] incr_mv;
   logic signed [17:0] vmv_in, vmv_ff;
   logic signed [17:0] raw_in, raw_ff;
   logic [2:0]         ch_in, ch_ff;
   logic [1:0]         idx_ff;
   logic               volt_in, volt_ff;
   logic               press_in, press_ff;
   logic               bad_in, bad_ff;

   // scale stage
   logic [16:0] vmag;
   logic [25:0] prod_in, prod_ff;
   logic        neg_in, neg_ff;

   // divide stage
   logic [16:0]        quot;
   logic signed [17:0] conv_in, conv_ff;

   // offset conversion, runs continuously from the registers
   logic [14:0]        null_mag, lvdt_mag;
   logic [23:0]        null_prod_in, null_prod_ff;
   logic [23:0]        lvdt_prod_in, lvdt_prod_ff;
   logic               null_neg_ff, lvdt_neg_ff;
   logic [14:0]        null_quot, lvdt_quot;
   logic signed [15:0] null_cnt, lvdt_cnt;
   logic signed [15:0] off_in, off_ff;

   // finish stage
   logic signed [17:0] pre;
   logic [13:0]        w_clamp, w_win, w_final;
   logic               axis_hit;
   logic signed [16:0] with_off;
   logic [14:0]        frame_in, frame_ff;
   logic               bad_out_in, bad_out_ff;
   logic               valid_in, valid_ff;

   // capture
   always_comb begin
      idx        = channel[1:0] - 2'd1;
      word       = store_ff[idx];
      word_dev   = $signed({1'b0, word}) - 15'sd8192;
      dev_prod   = 29'(word_dev) * 29'sd10000;
      dev_biased = dev_prod + (dev_prod[28] ? 29'sd8191 : 29'sd0);
      incr_mv    = 15'(dev_biased >>> 13);
      vmv_in     = 18'(value) + (incremental ? 18'(incr_mv) : 18'sd0);
      raw_in     = 18'(value) + (incremental ? $signed({4'd0, word}) : 18'sd0);
      ch_in      = channel;
      volt_in    = (value_kind == KIND_VOLT) || (value_kind == KIND_PRESS_VOLT);
      press_in   = (value_kind == KIND_PRESS_VOLT) || (value_kind == KIND_PRESS_RAW);
      bad_in     = (channel == 3'd0) || (channel > 3'd4);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vmv_ff   <= vmv_in;
         raw_ff   <= raw_in;
         ch_ff    <= ch_in;
         idx_ff   <= idx;
         volt_ff  <= volt_in;
         press_ff <= press_in;
         bad_ff   <= bad_in;
      end
   end

   // scale: |mV| * 819
   always_comb begin
      vmag    = vmv_ff[17] ? 17'(-vmv_ff) : 17'(vmv_ff);
      prod_in = {9'd0, vmag} * {16'd0, COUNTS_PER_V};
      neg_in  = vmv_ff[17];
   end

   // divide by 1000 and re-centre on mid-scale
   always_comb begin
      quot    = div1000(prod_ff);
      conv_in = neg_ff ? (18'sd8192 - $signed({1'b0, quot}))
                       : (18'sd8192 + $signed({1'b0, quot}));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      conv_ff <= conv_in;
   end

   // offset counts
   always_comb begin
      null_mag = cfg.null_offset_mv[14] ? 15'(-cfg.null_offset_mv)
                                        : 15'(cfg.null_offset_mv);
      lvdt_mag = cfg.lvdt_offset_mv[14] ? 15'(-cfg.lvdt_offset_mv)
                                        : 15'(cfg.lvdt_offset_mv);
      null_prod_in = {9'd0, null_mag} * {14'd0, COUNTS_PER_V};
      lvdt_prod_in = {9'd0, lvdt_mag} * {14'd0, COUNTS_PER_V};
      null_quot = 15'(div1000({2'd0, null_prod_ff}));
      lvdt_quot = 15'(div1000({2'd0, lvdt_prod_ff}));
      null_cnt = $signed({1'b0, null_quot});
      lvdt_cnt = $signed({1'b0, lvdt_quot});
      off_in   = (null_neg_ff ? -null_cnt : null_cnt)
               + (lvdt_neg_ff ? -lvdt_cnt : lvdt_cnt);
   end

   always_ff @(posedge clock) begin
      null_prod_ff <= null_prod_in;
      lvdt_prod_ff <= lvdt_prod_in;
      null_neg_ff  <= cfg.null_offset_mv[14];
      lvdt_neg_ff  <= cfg.lvdt_offset_mv[14];
      off_ff       <= off_in;
   end

   // finish: clamp, pressure window, offsets
   always_comb begin
      pre = volt_ff ? conv_ff : raw_ff;
      if (pre < 0) begin
         w_clamp = 14'd0;
      end else if (pre > $signed({4'd0, FULL_SCALE})) begin
         w_clamp = FULL_SCALE;
      end else begin
         w_clamp = pre[13:0];
      end

      w_win = w_clamp;
      if (press_ff) begin
         if (cfg.press_range_mode == RANGE_2V5) begin
            if (w_win > PRESS_HIGH) w_win = PRESS_HIGH_2;
            if (w_win < PRESS_LOW)  w_win = PRESS_LOW_2;
         end else if (cfg.press_range_mode == RANGE_5V) begin
            if (w_win > PRESS_HIGH) w_win = PRESS_HIGH;
            if (w_win < PRESS_LOW)  w_win = PRESS_LOW;
         end
         if (cfg.keep_positive && (w_win < MID_SCALE)) w_win = MID_SCALE;
      end
      store_wr_in = w_win;

      axis_hit = (ch_ff == cfg.axis_one_channel) || (ch_ff == cfg.axis_two_channel);
      with_off = $signed({3'd0, w_win}) + (axis_hit ? 17'(off_ff) : 17'sd0);
      if (with_off < 0) begin
         w_final = 14'd0;
      end else if (with_off > $signed({3'd0, FULL_SCALE})) begin
         w_final = FULL_SCALE;
      end else begin
         w_final = with_off[13:0];
      end

      frame_in   = bad_ff ? 15'd0 : {1'b1, w_final};
      bad_out_in = bad_ff;
      valid_in   = cmd.commit | (valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (cmd.commit && !bad_ff) begin
            store_ff[idx_ff] <= store_wr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         frame_ff   <= frame_in;
         bad_out_ff <= bad_out_in;
      end
   end

   assign status.out_free = ~valid_ff | rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign dac_frame       = frame_ff;
   assign status_bad      = bad_out_ff;

endmodule

// ===== design/dac_command_conditioner.sv =====
// DAC command conditioner: each request names one of four 14-bit DAC channels
// (1..4) and carries a value in millivolts or raw counts, absolute or
// incremental, plain or pressure. Millivolts map to counts as
// 8192 + 819*mV/1000 (truncating), the word is clamped to 0..16383, pressure
// requests are held to the window chosen by press_range_mode and optionally
// floored at mid-scale, and the per-channel stored word is updated. On the two
// axis channels the null and LVDT offsets, converted to counts, are added and
// the word clamped again; the response carries the word with update bit 14
// set. A channel outside 1..4 returns status 1 with a zero frame and leaves
// the stored words alone. One request is worked at a time: the request is
// captured at the accepting edge and passes through the controller's scale,
// reciprocal-divide and finish steps into the response register; only then
// does the controller return to its idle step and accept a new request. A
// waiting response holds the finish step until it is taken. Offset register
// writes reach the datapath through its offset product and sum registers.
// Registers sit at byte address 4*index, pready is always high, and stored
// words reset to zero.
module dac_command_conditioner (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] channel, [19:3] value, [23:20] zero
   input  logic [2:0]  req_tuser,   // [1:0] value_kind, [2] incremental
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] dac_frame, [15] zero
   output logic [0:0]  rsp_tuser,   // [0] status
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dcc_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   logic [14:0]   dac_frame;
   logic          status_bad;

   // register file
   dcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencing of one request at a time
   dcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   // conversion arithmetic, channel store and response register
   dcc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (dp_status),
      .cfg         (cfg),
      .channel     (req_tdata[2:0]),
      .value       ($signed(req_tdata[19:3])),
      .value_kind  (req_tuser[1:0]),
      .incremental (req_tuser[2]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .dac_frame   (dac_frame),
      .status_bad  (status_bad)
   );

   assign rsp_tdata = {1'b0, dac_frame};
   assign rsp_tuser = status_bad;

endmodule

// ===== design/dcc_checker.sv =====
module dcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a bad channel gives an all-zero frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 16'd0))
      else $error("bad channel response with non-zero frame");

   // a good response always carries the update bit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[14] && !rsp_tdata[15]))
      else $error("good response without update bit");

   // one request at a time: not ready straight after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind dac_command_conditioner dcc_checker u_dcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dcc_pkg::*;

   // one request of the directed script, with a typed-in result where it is obvious
   typedef struct packed {
      logic [2:0]         channel;
      logic signed [16:0] value;
      logic [1:0]         kind;
      logic               incremental;
      logic               typed;
      logic               want_status;
      logic [14:0]        want_frame;
   } script_row_type;

   typedef struct packed {
      logic        status;
      logic [14:0] frame;
   } dac_result_type;

   localparam int  SCRIPT_ROWS  = 20;
   localparam int  PHASE_ITEMS  = 205;
   localparam int  PHASES       = 6;
   localparam int  QUIET_LIMIT  = 4000;
   localparam int  HOLD_CYCLES  = 400;
   localparam int  HOLD_AFTER   = 950;
   localparam int  REPORT_LIMIT = 10;

   localparam longint MID_L   = MID_SCALE;
   localparam longint FULL_L  = FULL_SCALE;
   localparam longint HIGH_L  = PRESS_HIGH;
   localparam longint LOW_L   = PRESS_LOW;
   localparam longint HIGH2_L = PRESS_HIGH_2;
   localparam longint LOW2_L  = PRESS_LOW_2;
   localparam longint SPAN_L  = MV_SPAN;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // [2:0] channel, [19:3] value, [23:20] zero
   logic [2:0]  req_tuser   = '0;   // [1:0] value_kind, [2] incremental
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [14:0] dac_frame, [15] zero
   logic [0:0]  rsp_tuser;          // [0] status
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dac_command_conditioner u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the register file and of the per-channel stored words
   logic [2:0]         cfg_range;
   logic               cfg_keep_pos;
   logic signed [14:0] cfg_null_mv;
   logic signed [14:0] cfg_lvdt_mv;
   logic [2:0]         cfg_axis_one;
   logic [2:0]         cfg_axis_two;
   logic [13:0]        channel_word [4];

   dac_result_type pending_frames [$];

   // idle odds in percent, changed only between phases
   int send_idle_pct = 0;
   int take_idle_pct = 0;

   int requests_sent    = 0;
   int bad_channels     = 0;
   int settings_loaded  = 0;
   int responses_seen   = 0;
   int frame_mismatches = 0;
   int stray_frames     = 0;
   int hold_left        = 0;
   logic hold_done      = 1'b0;
   int quiet_cycles     = 0;

   script_row_type script [SCRIPT_ROWS];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // millivolts to counts, truncating toward zero
   function automatic longint counts_of_mv(input longint mv);
      return (819 * mv) / 1000;
   endfunction

   function automatic longint clamp_code(input longint v);
      if (v > FULL_L) return FULL_L;
      if (v < 0) return 0;
      return v;
   endfunction

   // works out the response for one request and updates the stored word
   function automatic dac_result_type condition_command(input logic [2:0] channel,
                                                        input logic signed [16:0] value,
                                                        input logic [1:0] kind,
                                                        input logic incremental);
      dac_result_type res;
      longint         level;
      longint         word;
      logic [1:0]     slot;
      logic           is_volt;
      logic           is_press;
      if (channel < 3'd1 || channel > 3'd4) begin
         res.status = 1'b1;
         res.frame  = '0;
         return res;
      end
      slot     = 2'(channel - 3'd1);
      is_volt  = (kind == KIND_VOLT) || (kind == KIND_PRESS_VOLT);
      is_press = (kind == KIND_PRESS_VOLT) || (kind == KIND_PRESS_RAW);
      word     = channel_word[slot];
      level    = value;
      if (is_volt) begin
         // stored word back to millivolts before the increment
         if (incremental) level += ((word - MID_L) * SPAN_L) / MID_L;
         level = MID_L + counts_of_mv(level);
      end else if (incremental) begin
         level += word;
      end
      level = clamp_code(level);
      if (is_press) begin
         if (cfg_range == RANGE_2V5) begin
            if (level > HIGH_L) level = HIGH2_L;
            if (level < LOW_L) level = LOW2_L;
         end else if (cfg_range == RANGE_5V) begin
            if (level > HIGH_L) level = HIGH_L;
            if (level < LOW_L) level = LOW_L;
         end
         if (cfg_keep_pos && level < MID_L) level = MID_L;
      end
      channel_word[slot] = level[13:0];
      // axis channels get both offsets, added once even if both axes match
      if (channel == cfg_axis_one || channel == cfg_axis_two)
         level += counts_of_mv(cfg_null_mv) + counts_of_mv(cfg_lvdt_mv);
      level      = clamp_code(level);
      res.status = 1'b0;
      res.frame  = {1'b1, level[13:0]};
      return res;
   endfunction

   // offers one request; tvalid stays high after acceptance unless the next call idles
   task automatic offer_request(input logic [2:0] channel, input logic signed [16:0] value,
                                input logic [1:0] kind, input logic incremental,
                                input logic typed, input dac_result_type typed_result);
      dac_result_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, value, channel};
      req_tuser  <= {incremental, kind};
      do @(posedge clock); while (!req_tready);
      predicted = condition_command(channel, value, kind, incremental);
      pending_frames.push_back(typed ? typed_result : predicted);
      requests_sent++;
      if (predicted.status) bad_channels++;
   endtask

   // setup cycle then access cycle; psel is dropped by the caller after the last write
   task automatic write_register(input logic [2:0] index, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_PRESS_RANGE: cfg_range    = value[2:0];
         REG_KEEP_POS:    cfg_keep_pos = value[0];
         REG_NULL_OFFSET: cfg_null_mv  = value[14:0];
         REG_LVDT_OFFSET: cfg_lvdt_mv  = value[14:0];
         REG_AXIS_ONE:    cfg_axis_one = value[2:0];
         REG_AXIS_TWO:    cfg_axis_two = value[2:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input int range_mode, input int keep_pos, input int null_mv,
                                input int lvdt_mv, input int axis_one, input int axis_two);
      write_register(REG_PRESS_RANGE, range_mode);
      write_register(REG_KEEP_POS, keep_pos);
      write_register(REG_NULL_OFFSET, null_mv);
      write_register(REG_LVDT_OFFSET, lvdt_mv);
      write_register(REG_AXIS_ONE, axis_one);
      write_register(REG_AXIS_TWO, axis_two);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_loaded++;
      // offsets pass through the datapath's product and sum registers before use
      repeat (4) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [16:0] draw_value();
      case ($urandom_range(0, 5))
         0: return 17'($urandom);
         1: return 17'(int'($urandom_range(0, 20000)) - 10000);    // plausible millivolts
         2: return 17'($urandom_range(0, 16383));                   // plausible raw counts
         3: return 17'(int'($urandom_range(0, 1000)) - 500);        // small nudges
         4: begin
            case ($urandom_range(0, 3))
               0: return 17'h10000;
               1: return 17'h0ffff;
               2: return 17'h00000;
               default: return 17'h1ffff;
            endcase
         end
         default: return 17'(int'($urandom_range(0, 40000)) - 20000);
      endcase
   endfunction

   function automatic logic [2:0] draw_channel();
      int pick;
      pick = $urandom_range(0, 3);
      // one request in ten names a channel that does not exist
      if ($urandom_range(0, 9) == 0) return (pick == 0) ? 3'd0 : 3'(pick + 4);
      return 3'(pick + 1);
   endfunction

   function automatic int draw_offset();
      // mostly the documented span, now and then the whole field
      if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 32767)) - 16384;
      return int'($urandom_range(0, 20000)) - 10000;
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      frame_mismatches++;
      if (frame_mismatches <= REPORT_LIMIT)
         $display("mismatch in %s of response %0d: expected %h, got %h",
                  field, responses_seen, want, got);
   endfunction

   // response side: check what is taken, then decide tready for the next edge
   always @(posedge clock) begin
      dac_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (pending_frames.size() == 0) begin
            stray_frames++;
            if (stray_frames <= REPORT_LIMIT)
               $display("response %0d with nothing outstanding: frame %h status %b",
                        responses_seen, rsp_tdata[14:0], rsp_tuser[0]);
         end else begin
            want = pending_frames.pop_front();
            if (rsp_tdata[14:0] !== want.frame) note_mismatch("dac_frame", want.frame, rsp_tdata[14:0]);
            if (rsp_tuser[0] !== want.status) note_mismatch("status", want.status, rsp_tuser[0]);
         end
      end
      // one long hold-off so that the block fills and stalls the request side
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && responses_seen >= HOLD_AFTER) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // watchdog: a long run of cycles with no handshake at all ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_frames.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int             phase;
      int             n;
      script_row_type row;
      dac_result_type typed_result;

      // register reset values
      cfg_range    = RANGE_2V5;
      cfg_keep_pos = 1'b0;
      cfg_null_mv  = '0;
      cfg_lvdt_mv  = '0;
      cfg_axis_one = 3'd1;
      cfg_axis_two = 3'd2;
      for (n = 0; n < 4; n++) channel_word[n] = '0;

      // channel, value, kind, incremental, typed, status, frame
      script = '{
         '{3'd0, 17'sd0,     KIND_VOLT,       1'b0, 1'b1, 1'b1, 15'h0000},  // bad channels
         '{3'd7, 17'h10000,  KIND_PRESS_RAW,  1'b1, 1'b1, 1'b1, 15'h0000},
         '{3'd5, 17'sd65535, KIND_RAW,        1'b0, 1'b1, 1'b1, 15'h0000},
         '{3'd6, 17'sd1,     KIND_PRESS_VOLT, 1'b1, 1'b1, 1'b1, 15'h0000},
         '{3'd3, 17'sd0,     KIND_VOLT,       1'b0, 1'b1, 1'b0, 15'h6000},  // mid-scale
         '{3'd3, 17'sd65535, KIND_VOLT,       1'b0, 1'b1, 1'b0, 15'h7fff},  // clamp high
         '{3'd4, 17'h10000,  KIND_VOLT,       1'b0, 1'b1, 1'b0, 15'h4000},  // clamp low
         '{3'd3, 17'sd65535, KIND_RAW,        1'b0, 1'b1, 1'b0, 15'h7fff},
         '{3'd4, 17'h10000,  KIND_RAW,        1'b0, 1'b1, 1'b0, 15'h4000},
         '{3'd3, 17'sd16000, KIND_PRESS_RAW,  1'b0, 1'b1, 1'b0, 15'h67ff},  // 2.5V window top
         '{3'd4, 17'sd0,     KIND_PRESS_RAW,  1'b0, 1'b1, 1'b0, 15'h5801},  // 2.5V window bottom
         '{3'd4, 17'sd0,     KIND_PRESS_VOLT, 1'b0, 1'b1, 1'b0, 15'h6000},
         '{3'd1, 17'sd5000,  KIND_RAW,        1'b0, 1'b1, 1'b0, 15'h5388},  // axis, no offset
         '{3'd3, 17'sd100,   KIND_RAW,        1'b1, 1'b0, 1'b0, 15'h0000},  // increments
         '{3'd1, -17'sd1234, KIND_VOLT,       1'b1, 1'b0, 1'b0, 15'h0000},
         '{3'd2, 17'h10000,  KIND_RAW,        1'b1, 1'b0, 1'b0, 15'h0000},
         '{3'd2, 17'sd65535, KIND_PRESS_VOLT, 1'b1, 1'b0, 1'b0, 15'h0000},
         '{3'd4, -17'sd5000, KIND_PRESS_RAW,  1'b1, 1'b0, 1'b0, 15'h0000},
         '{3'd2, 17'sd10000, KIND_VOLT,       1'b0, 1'b0, 1'b0, 15'h0000},
         '{3'd1, 17'sd32768, KIND_PRESS_RAW,  1'b1, 1'b0, 1'b0, 15'h0000}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on the reset settings, sender and receiver both idling
      send_idle_pct = 17;
      take_idle_pct = 80;
      for (n = 0; n < SCRIPT_ROWS; n++) begin
         row                 = script[n];
         typed_result.status = row.want_status;
         typed_result.frame  = row.want_frame;
         offer_request(row.channel, row.value, row.kind, row.incremental,
                       row.typed, typed_result);
      end
      wait_drained();

      // random part: new settings each phase, idling pattern changes every two phases
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_settings(RANGE_5V, 1, 10000, -10000, 3, 3);
            1: load_settings(7, 0, -10000, -10000, 0, 4);
            2: load_settings(RANGE_2V5, 1, 10000, 10000, 7, 1);
            3: load_settings(2, 0, 0, 5, 2, 2);
            default: load_settings($urandom_range(0, 7), $urandom_range(0, 1), draw_offset(),
                                   draw_offset(), $urandom_range(0, 7), $urandom_range(0, 7));
         endcase
         case (phase / 2)
            0: begin send_idle_pct = 17; take_idle_pct = 80; end
            1: begin send_idle_pct = 80; take_idle_pct = 17; end
            default: begin send_idle_pct = 0; take_idle_pct = 0; end
         endcase
         typed_result = '0;
         for (n = 0; n < PHASE_ITEMS; n++)
            offer_request(draw_channel(), draw_value(), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 1'b0, typed_result);
         // sender waits here until every response of the phase is back
         wait_drained();
      end

      // a little slack for anything the block might still push out
      repeat (12) @(posedge clock);

      $display("%0d requests (%0d to bad channels) under %0d register settings, %0d responses",
               requests_sent, bad_channels, settings_loaded + 1, responses_seen);
      $display("%0d field mismatches, %0d unexpected responses, %0d missing",
               frame_mismatches, stray_frames, pending_frames.size());
      if (frame_mismatches == 0 && stray_frames == 0 && pending_frames.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
